FILE: rtl/c8x_pkg.sv
`timescale 1ns / 1ps

package c8x_pkg;

    // program counter after reset
    localparam logic [11:0] PC_RESET = 12'h200;

    // entries of the queue between decode and execute
    localparam int QUEUE_DEPTH = 2;

    // instruction class as handed from decode to execute
    typedef enum logic [3:0] {
        CLS_NOP    = 4'd0,   // advance the pc only
        CLS_CLS    = 4'd1,   // clear screen request
        CLS_RET    = 4'd2,   // return from subroutine
        CLS_JP     = 4'd3,   // jump to nnn
        CLS_CALL   = 4'd4,   // call nnn
        CLS_SEI    = 4'd5,   // skip if vx == nn
        CLS_SNEI   = 4'd6,   // skip if vx != nn
        CLS_SER    = 4'd7,   // skip if vx == vy
        CLS_SNER   = 4'd8,   // skip if vx != vy
        CLS_LDI    = 4'd9,   // vx = nn
        CLS_ADDI   = 4'd10,  // vx += nn, flag untouched
        CLS_ALU    = 4'd11,  // register to register op
        CLS_LDIDX  = 4'd12,  // i = nnn
        CLS_JPV0   = 4'd13,  // pc = nnn + v0
        CLS_ADDIDX = 4'd14,  // i += vx
        CLS_ILL    = 4'd15   // illegal word
    } cls_t;

    // register to register ops, coded as the low nibble of 8xyn
    typedef enum logic [2:0] {
        ALU_MOV  = 3'd0,
        ALU_OR   = 3'd1,
        ALU_AND  = 3'd2,
        ALU_XOR  = 3'd3,
        ALU_ADD  = 3'd4,
        ALU_SUB  = 3'd5,
        ALU_SHR  = 3'd6,
        ALU_SUBN = 3'd7
    } alu_t;

    typedef enum logic [1:0] {
        STAT_OK        = 2'd0,
        STAT_ILLEGAL   = 2'd1,
        STAT_OVERFLOW  = 2'd2,
        STAT_UNDERFLOW = 2'd3
    } status_t;

    typedef struct packed {
        cls_t        cls;
        alu_t        alu;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [11:0] nnn;
    } dec_t;

    typedef struct packed {
        logic [11:0] next_pc;
        logic [15:0] index_value;
        logic        reg_write_valid;
        logic [3:0]  reg_write_index;
        logic [7:0]  reg_write_value;
        logic [7:0]  flag_value;
        logic        clear_screen;
        status_t     status;
    } res_t;

endpackage

FILE: rtl/c8x_decode.sv
`timescale 1ns / 1ps

module c8x_decode
    import c8x_pkg::*;
(
    input  logic [15:0] instr,
    output dec_t        dec
);

    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JP    = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SEI   = 4'h3;
    localparam logic [3:0] OP_SNEI  = 4'h4;
    localparam logic [3:0] OP_SER   = 4'h5;
    localparam logic [3:0] OP_LDI   = 4'h6;
    localparam logic [3:0] OP_ADDI  = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SNER  = 4'h9;
    localparam logic [3:0] OP_LDIDX = 4'hA;
    localparam logic [3:0] OP_JPV0  = 4'hB;
    localparam logic [3:0] OP_RND   = 4'hC;
    localparam logic [3:0] OP_DRW   = 4'hD;
    localparam logic [3:0] OP_KEY   = 4'hE;
    localparam logic [3:0] OP_MISC  = 4'hF;

    localparam logic [15:0] W_CLS = 16'h00E0;
    localparam logic [15:0] W_RET = 16'h00EE;

    localparam logic [3:0] SUB_SHL = 4'hE;

    localparam logic [7:0] KEY_SKP  = 8'h9E;
    localparam logic [7:0] KEY_SKNP = 8'hA1;

    localparam logic [7:0] MISC_ADDI = 8'h1E;
    localparam logic [7:0] MISC_GDT  = 8'h07;
    localparam logic [7:0] MISC_KEY  = 8'h0A;
    localparam logic [7:0] MISC_SDT  = 8'h15;
    localparam logic [7:0] MISC_SST  = 8'h18;
    localparam logic [7:0] MISC_FNT  = 8'h29;
    localparam logic [7:0] MISC_BCD  = 8'h33;
    localparam logic [7:0] MISC_STR  = 8'h55;
    localparam logic [7:0] MISC_LDR  = 8'h65;

    logic [3:0] op;
    logic [3:0] n;
    logic [7:0] nn;

    assign op = instr[15:12];
    assign n  = instr[3:0];
    assign nn = instr[7:0];

    always_comb begin
        dec.x   = instr[11:8];
        dec.y   = instr[7:4];
        dec.nnn = instr[11:0];
        dec.alu = alu_t'(n[2:0]);
        dec.cls = CLS_NOP;
        unique case (op) inside
            OP_SYS: begin
                if (instr == W_CLS) begin
                    dec.cls = CLS_CLS;
                end else if (instr == W_RET) begin
                    dec.cls = CLS_RET;
                end else begin
                    dec.cls = CLS_NOP;   // machine code call, not modeled
                end
            end
            OP_JP:    dec.cls = CLS_JP;
            OP_CALL:  dec.cls = CLS_CALL;
            OP_SEI:   dec.cls = CLS_SEI;
            OP_SNEI:  dec.cls = CLS_SNEI;
            OP_SER:   dec.cls = CLS_SER;
            OP_LDI:   dec.cls = CLS_LDI;
            OP_ADDI:  dec.cls = CLS_ADDI;
            OP_ALU: begin
                if (!n[3]) begin
                    dec.cls = CLS_ALU;
                end else if (n == SUB_SHL) begin
                    dec.cls = CLS_NOP;
                end else begin
                    dec.cls = CLS_ILL;
                end
            end
            OP_SNER:  dec.cls = CLS_SNER;
            OP_LDIDX: dec.cls = CLS_LDIDX;
            OP_JPV0:  dec.cls = CLS_JPV0;
            OP_RND, OP_DRW: dec.cls = CLS_NOP;
            OP_KEY: begin
                if (nn == KEY_SKP || nn == KEY_SKNP) begin
                    dec.cls = CLS_NOP;
                end else begin
                    dec.cls = CLS_ILL;
                end
            end
            OP_MISC: begin
                unique case (nn) inside
                    MISC_ADDI: dec.cls = CLS_ADDIDX;
                    MISC_GDT, MISC_KEY, MISC_SDT, MISC_SST,
                    MISC_FNT, MISC_BCD, MISC_STR, MISC_LDR: dec.cls = CLS_NOP;
                    default: dec.cls = CLS_ILL;
                endcase
            end
            default: dec.cls = CLS_ILL;
        endcase
    end

endmodule

FILE: rtl/c8x_queue.sv
`timescale 1ns / 1ps

module c8x_queue
    import c8x_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  dec_t push_data,
    output logic pop_valid,
    input  logic pop_ready,
    output dec_t pop_data
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    dec_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
            r = '0;
        end else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + CNT_W'(1);
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: rtl/c8x_exec.sv
`timescale 1ns / 1ps

module c8x_exec
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        q_valid,
    output logic        q_ready,
    input  dec_t        q_data,
    input  logic        cfg_we,
    input  logic [11:0] cfg_pc,
    output logic        out_valid,
    input  logic        out_ready,
    output res_t        out_data
);

    localparam int SIDX = $clog2(STACK_DEPTH);
    localparam int DW   = $clog2(STACK_DEPTH + 1);
    localparam logic [3:0] VF_IDX = 4'hF;
    localparam logic [3:0] V0_IDX = 4'h0;

    // execute stage
    dec_t        exe_reg;
    logic        exe_vld_reg;
    logic [7:0]  opx_reg;
    logic [7:0]  opy_reg;

    // architectural state
    logic [7:0]  rf_mem [16];
    logic [15:0] rf_vld_reg;
    logic [7:0]  vf_reg;
    logic [7:0]  v0_reg;
    logic [11:0] pc_reg;
    logic [15:0] idx_reg;
    logic [DW-1:0] depth_reg;
    logic [DW-1:0] depth_next;
    logic [11:0] stk_mem [STACK_DEPTH];
    logic [11:0] top_reg;

    // output register
    res_t        out_reg;
    logic        out_vld_reg;

    logic        fire;
    logic        exe_load;
    logic [7:0]  vx;
    logic [7:0]  vy;
    logic [8:0]  sum;
    logic [11:0] pc_adv;
    logic [11:0] pc_skip;
    logic [11:0] pc_new;
    logic [15:0] idx_new;
    logic        wr;
    logic [7:0]  res;
    logic        wf;
    logic [7:0]  flag;
    logic [7:0]  vf_new;
    logic        clr;
    status_t     stat;
    logic        push;
    logic        pop;
    logic        rf_we;
    logic        stk_we;
    logic [DW-1:0]   depth_m1;
    logic [SIDX-1:0] stk_ra;
    res_t        res_next;

    assign fire     = exe_vld_reg && (!out_vld_reg || out_ready);
    assign q_ready  = !exe_vld_reg || fire;
    assign exe_load = q_valid && q_ready;

    assign out_valid = out_vld_reg;
    assign out_data  = out_reg;

    assign vx      = (exe_reg.x == VF_IDX) ? vf_reg : opx_reg;
    assign vy      = (exe_reg.y == VF_IDX) ? vf_reg : opy_reg;
    assign sum     = {1'b0, vx} + {1'b0, vy};
    assign pc_adv  = pc_reg + 12'd2;
    assign pc_skip = pc_reg + 12'd4;

    always_comb begin
        pc_new  = pc_adv;
        idx_new = idx_reg;
        wr      = 1'b0;
        res     = '0;
        wf      = 1'b0;
        flag    = '0;
        clr     = 1'b0;
        stat    = STAT_OK;
        push    = 1'b0;
        pop     = 1'b0;
        unique case (exe_reg.cls)
            CLS_NOP: ;
            CLS_CLS: clr = 1'b1;
            CLS_RET: begin
                if (depth_reg == '0) begin
                    stat   = STAT_UNDERFLOW;
                    pc_new = pc_reg;
                end else begin
                    pop    = 1'b1;
                    pc_new = top_reg;
                end
            end
            CLS_JP: pc_new = exe_reg.nnn;
            CLS_CALL: begin
                if (depth_reg == DW'(STACK_DEPTH)) begin
                    stat   = STAT_OVERFLOW;
                    pc_new = pc_reg;
                end else begin
                    push   = 1'b1;
                    pc_new = exe_reg.nnn;
                end
            end
            CLS_SEI:  pc_new = (vx == exe_reg.nnn[7:0]) ? pc_skip : pc_adv;
            CLS_SNEI: pc_new = (vx != exe_reg.nnn[7:0]) ? pc_skip : pc_adv;
            CLS_SER:  pc_new = (vx == vy) ? pc_skip : pc_adv;
            CLS_SNER: pc_new = (vx != vy) ? pc_skip : pc_adv;
            CLS_LDI: begin
                wr  = 1'b1;
                res = exe_reg.nnn[7:0];
            end
            CLS_ADDI: begin
                wr  = 1'b1;
                res = vx + exe_reg.nnn[7:0];
            end
            CLS_ALU: begin
                wr = 1'b1;
                case (exe_reg.alu)
                    ALU_MOV: res = vy;
                    ALU_OR:  res = vx | vy;
                    ALU_AND: res = vx & vy;
                    ALU_XOR: res = vx ^ vy;
                    ALU_ADD: begin
                        wf   = 1'b1;
                        res  = sum[7:0];
                        flag = {7'd0, sum[8]};
                    end
                    ALU_SUB: begin
                        wf   = 1'b1;
                        res  = vx - vy;
                        flag = {7'd0, (vx > vy)};
                    end
                    ALU_SHR: begin
                        wf   = 1'b1;
                        res  = {1'b0, vx[7:1]};
                        flag = {7'd0, vx[0]};
                    end
                    ALU_SUBN: begin
                        wf   = 1'b1;
                        res  = vy - vx;
                        flag = {7'd0, !(vy > vx)};
                    end
                    default: ;
                endcase
            end
            CLS_LDIDX:  idx_new = {4'd0, exe_reg.nnn};
            CLS_JPV0:   pc_new  = exe_reg.nnn + {4'd0, v0_reg};
            CLS_ADDIDX: idx_new = idx_reg + {8'd0, vx};
            CLS_ILL: begin
                stat   = STAT_ILLEGAL;
                pc_new = pc_reg;
            end
            default: pc_new = pc_reg;
        endcase
    end

    // vx is written after the flag, so it wins when x is vf
    assign vf_new = (wr && exe_reg.x == VF_IDX) ? res : (wf ? flag : vf_reg);

    assign rf_we  = fire && wr && (exe_reg.x != VF_IDX);
    assign stk_we = fire && push;

    always_comb begin
        depth_next = depth_reg;
        if (fire && push) begin
            depth_next = depth_reg + DW'(1);
        end else if (fire && pop) begin
            depth_next = depth_reg - DW'(1);
        end
    end

    // keep the stack top prefetched for the following return
    assign depth_m1 = depth_next - DW'(1);
    assign stk_ra   = (depth_next == '0) ? '0 : depth_m1[SIDX-1:0];

    always_comb begin
        res_next.next_pc         = pc_new;
        res_next.index_value     = idx_new;
        res_next.reg_write_valid = wr;
        res_next.reg_write_index = wr ? exe_reg.x : 4'd0;
        res_next.reg_write_value = wr ? res : 8'd0;
        res_next.flag_value      = vf_new;
        res_next.clear_screen    = clr;
        res_next.status          = stat;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            exe_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
            rf_vld_reg  <= '0;
            vf_reg      <= '0;
            v0_reg      <= '0;
            pc_reg      <= PC_RESET;
            idx_reg     <= '0;
            depth_reg   <= '0;
        end else begin
            if (cfg_we) begin
                pc_reg <= cfg_pc;
            end
            if (fire) begin
                pc_reg  <= pc_new;
                idx_reg <= idx_new;
                vf_reg  <= vf_new;
                if (wr && exe_reg.x == V0_IDX) begin
                    v0_reg <= res;
                end
            end
            if (rf_we) begin
                rf_vld_reg[exe_reg.x] <= 1'b1;
            end
            depth_reg <= depth_next;
            if (exe_load) begin
                exe_vld_reg <= 1'b1;
            end else if (fire) begin
                exe_vld_reg <= 1'b0;
            end
            if (fire) begin
                out_vld_reg <= 1'b1;
            end else if (out_ready) begin
                out_vld_reg <= 1'b0;
            end
        end
    end

    // register file with write bypass into the operand registers
    always_ff @(posedge aclk) begin
        if (rf_we) begin
            rf_mem[exe_reg.x] <= res;
        end
        if (exe_load) begin
            exe_reg <= q_data;
            if (rf_we && q_data.x == exe_reg.x) begin
                opx_reg <= res;
            end else if (rf_vld_reg[q_data.x]) begin
                opx_reg <= rf_mem[q_data.x];
            end else begin
                opx_reg <= '0;
            end
            if (rf_we && q_data.y == exe_reg.x) begin
                opy_reg <= res;
            end else if (rf_vld_reg[q_data.y]) begin
                opy_reg <= rf_mem[q_data.y];
            end else begin
                opy_reg <= '0;
            end
        end
        if (fire) begin
            out_reg <= res_next;
        end
    end

    // return stack, read data registered
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[depth_reg[SIDX-1:0]] <= pc_adv;
            top_reg <= pc_adv;
        end else begin
            top_reg <= stk_mem[stk_ra];
        end
    end

endmodule

FILE: rtl/chip8_instruction_execute.sv
// chip8_instruction_execute: runs one chip-8 instruction word per input beat
// input channel s_valid / s_ready / s_instruction carries one 16-bit word per beat
// result channel m_valid / m_ready carries one result beat per instruction:
//   pc after the instruction, index register, the data register write made,
//   vf, the clear screen request and a status code (ok, illegal, stack errors)
// config channel cfg_valid / cfg_ready / cfg_program_start loads the pc;
//   cfg_ready is always high, write only while no instruction is in flight
// path: the word is decoded into a two-entry queue, then loaded into the execute
//   register, and its result is registered in the output register
// throughput: one instruction per cycle unless m_ready stalls it; execute loads both
//   source registers with the word from a two-port register file, bypassing the writer
// reset (aresetn low, synchronous): pc = 0x200, index = 0, all vx = 0,
//   stack empty, queue and output register empty
// when m_ready stays low the output register holds its beat, execute stalls,
//   the queue fills and s_ready falls once both queue entries are taken
`timescale 1ns / 1ps

module chip8_instruction_execute
    import c8x_pkg::*;
#(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // config channel
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [11:0] cfg_program_start,
    // instruction channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_instruction,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [11:0] m_next_pc,
    output logic [15:0] m_index_value,
    output logic        m_reg_write_valid,
    output logic [3:0]  m_reg_write_index,
    output logic [7:0]  m_reg_write_value,
    output logic [7:0]  m_flag_value,
    output logic        m_clear_screen,
    output logic [1:0]  m_status
);

    dec_t dec;        // classified word from the front end
    dec_t q_data;     // head of the queue
    logic q_valid;
    logic q_ready;
    res_t res;

    // config write goes straight into the pc register, never back-pressured
    assign cfg_ready = 1'b1;

    // front end: classify the word before it enters the queue
    c8x_decode u_decode (
        .instr (s_instruction),
        .dec   (dec)
    );

    // decouples input acceptance from execute stalls
    c8x_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (s_valid),
        .push_ready (s_ready),
        .push_data  (dec),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_data   (q_data)
    );

    // back end: register file, pc, index, stack and the output register
    c8x_exec #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_exec (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_valid   (q_valid),
        .q_ready   (q_ready),
        .q_data    (q_data),
        .cfg_we    (cfg_valid && cfg_ready),
        .cfg_pc    (cfg_program_start),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (res)
    );

    // unpack the result beat onto the ports
    assign m_next_pc         = res.next_pc;
    assign m_index_value     = res.index_value;
    assign m_reg_write_valid = res.reg_write_valid;
    assign m_reg_write_index = res.reg_write_index;
    assign m_reg_write_value = res.reg_write_value;
    assign m_flag_value      = res.flag_value;
    assign m_clear_screen    = res.clear_screen;
    assign m_status          = res.status;

endmodule

FILE: rtl/c8x_checker.sv
`timescale 1ns / 1ps

module c8x_checker
    import c8x_pkg::*;
(
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [11:0] m_next_pc,
    input logic [15:0] m_index_value,
    input logic        m_reg_write_valid,
    input logic [3:0]  m_reg_write_index,
    input logic [7:0]  m_reg_write_value,
    input logic [7:0]  m_flag_value,
    input logic        m_clear_screen,
    input logic [1:0]  m_status
);

    // a stalled result beat stays up
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result beat dropped while stalled");

    // and keeps its pc, index, status and flag fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> $stable(m_next_pc) && $stable(m_index_value)
            && $stable(m_status) && $stable(m_flag_value))
        else $error("result payload changed while stalled");

    // no register write means zero write fields
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reg_write_valid |-> m_reg_write_index == 4'd0
            && m_reg_write_value == 8'd0)
        else $error("write fields set without a register write");

    // a faulting instruction writes nothing and requests no clear
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == STAT_ILLEGAL || m_status == STAT_OVERFLOW
            || m_status == STAT_UNDERFLOW) |-> !m_reg_write_valid && !m_clear_screen)
        else $error("faulting instruction had side effects");

endmodule

bind chip8_instruction_execute c8x_checker u_chk (.*);

FILE: verif/tb.sv
`timescale 1ns / 1ps

module tb;
    import c8x_pkg::*;

    localparam int STACK_DEPTH   = 16;
    localparam int SETTLE_CYCLES = 4;
    localparam int HOLD_CYCLES   = 150;
    localparam int STALL_LIMIT   = 2000;

    // major opcodes, top nibble of the instruction word
    localparam logic [3:0] OP_SYS   = 4'h0;
    localparam logic [3:0] OP_JP    = 4'h1;
    localparam logic [3:0] OP_CALL  = 4'h2;
    localparam logic [3:0] OP_SEI   = 4'h3;
    localparam logic [3:0] OP_SNEI  = 4'h4;
    localparam logic [3:0] OP_SER   = 4'h5;
    localparam logic [3:0] OP_LDI   = 4'h6;
    localparam logic [3:0] OP_ADDI  = 4'h7;
    localparam logic [3:0] OP_ALU   = 4'h8;
    localparam logic [3:0] OP_SNER  = 4'h9;
    localparam logic [3:0] OP_LDIDX = 4'hA;
    localparam logic [3:0] OP_JPV0  = 4'hB;
    localparam logic [3:0] OP_RND   = 4'hC;
    localparam logic [3:0] OP_DRW   = 4'hD;
    localparam logic [3:0] OP_KEY   = 4'hE;
    localparam logic [3:0] OP_MISC  = 4'hF;

    localparam logic [15:0] W_CLS = 16'h00E0;
    localparam logic [15:0] W_RET = 16'h00EE;

    // low nibble of 8xyn outside the alu_t range
    localparam logic [3:0] ALU_SHL_NOP = 4'hE;
    localparam logic [3:0] ALU_RSVD_LO = 4'h8;
    localparam logic [3:0] ALU_RSVD_HI = 4'hF;

    localparam logic [7:0] KEY_SKP   = 8'h9E;
    localparam logic [7:0] KEY_SKNP  = 8'hA1;
    localparam logic [7:0] FX_LD_DT  = 8'h07;
    localparam logic [7:0] FX_LD_K   = 8'h0A;
    localparam logic [7:0] FX_SET_DT = 8'h15;
    localparam logic [7:0] FX_SET_ST = 8'h18;
    localparam logic [7:0] FX_ADD_I  = 8'h1E;
    localparam logic [7:0] FX_FONT   = 8'h29;
    localparam logic [7:0] FX_BCD    = 8'h33;
    localparam logic [7:0] FX_STORE  = 8'h55;
    localparam logic [7:0] FX_LOAD   = 8'h65;

    typedef enum logic [1:0] {RX_OPEN, RX_COIN, RX_SPARSE, RX_CADENCE} rx_mode_t;

    logic        aclk;
    logic        aresetn;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [11:0] cfg_program_start;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_instruction;
    logic        m_valid;
    logic        m_ready;
    logic [11:0] m_next_pc;
    logic [15:0] m_index_value;
    logic        m_reg_write_valid;
    logic [3:0]  m_reg_write_index;
    logic [7:0]  m_reg_write_value;
    logic [7:0]  m_flag_value;
    logic        m_clear_screen;
    logic [1:0]  m_status;

    chip8_instruction_execute #(
        .STACK_DEPTH(STACK_DEPTH)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_program_start (cfg_program_start),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_instruction     (s_instruction),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_next_pc         (m_next_pc),
        .m_index_value     (m_index_value),
        .m_reg_write_valid (m_reg_write_valid),
        .m_reg_write_index (m_reg_write_index),
        .m_reg_write_value (m_reg_write_value),
        .m_flag_value      (m_flag_value),
        .m_clear_screen    (m_clear_screen),
        .m_status          (m_status)
    );

    // shadow cpu state
    logic [7:0]  vreg [16];
    logic [11:0] cpu_pc;
    logic [15:0] cpu_index;
    logic [11:0] ret_stack [STACK_DEPTH];
    int          stack_level;
    res_t        predicted_outcomes [$];
    res_t        head;

    int errors = 0;
    int burst_left = 0;
    int call_weight = 5;
    int ret_weight = 5;
    int stall_count = 0;
    bit gaps_on = 1'b1;
    bit hold_request = 1'b0;

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // runs one word on the shadow cpu and queues the result beat it must produce
    task automatic execute_word(input logic [15:0] w);
        logic [3:0]  x, y, n;
        logic [7:0]  nn, vx, vy, res, flag;
        logic [11:0] nnn, pc_next, pc_skip, new_pc;
        logic [8:0]  sum;
        logic        wr, wf, clr;
        status_t     st;
        res_t        r;
        x = w[11:8];
        y = w[7:4];
        n = w[3:0];
        nn = w[7:0];
        nnn = w[11:0];
        vx = vreg[x];
        vy = vreg[y];
        pc_next = cpu_pc + 12'd2;
        pc_skip = cpu_pc + 12'd4;
        new_pc = cpu_pc;
        st = STAT_OK;
        clr = 1'b0;
        wr = 1'b0;
        wf = 1'b0;
        res = '0;
        flag = '0;
        case (w[15:12])
            OP_SYS: begin
                if (w == W_CLS) begin
                    clr = 1'b1;
                    new_pc = pc_next;
                end else if (w == W_RET) begin
                    if (stack_level == 0) begin
                        st = STAT_UNDERFLOW;
                    end else begin
                        stack_level--;
                        new_pc = ret_stack[stack_level];
                    end
                end else begin
                    new_pc = pc_next;
                end
            end
            OP_JP: new_pc = nnn;
            OP_CALL: begin
                if (stack_level >= STACK_DEPTH) begin
                    st = STAT_OVERFLOW;
                end else begin
                    ret_stack[stack_level] = pc_next;
                    stack_level++;
                    new_pc = nnn;
                end
            end
            OP_SEI:  new_pc = (vx == nn) ? pc_skip : pc_next;
            OP_SNEI: new_pc = (vx != nn) ? pc_skip : pc_next;
            OP_SER:  new_pc = (vx == vy) ? pc_skip : pc_next;
            OP_SNER: new_pc = (vx != vy) ? pc_skip : pc_next;
            OP_LDI: begin
                wr = 1'b1;
                res = nn;
                new_pc = pc_next;
            end
            OP_ADDI: begin
                wr = 1'b1;
                res = vx + nn;
                new_pc = pc_next;
            end
            OP_ALU: begin
                new_pc = pc_next;
                if (!n[3]) begin
                    wr = 1'b1;
                    case (alu_t'(n[2:0]))
                        ALU_MOV: res = vy;
                        ALU_OR:  res = vx | vy;
                        ALU_AND: res = vx & vy;
                        ALU_XOR: res = vx ^ vy;
                        ALU_ADD: begin
                            sum = {1'b0, vx} + {1'b0, vy};
                            res = sum[7:0];
                            wf = 1'b1;
                            flag = {7'd0, sum[8]};
                        end
                        ALU_SUB: begin
                            res = vx - vy;
                            wf = 1'b1;
                            flag = (vx > vy) ? 8'd1 : 8'd0;
                        end
                        ALU_SHR: begin
                            res = vx >> 1;
                            wf = 1'b1;
                            flag = {7'd0, vx[0]};
                        end
                        ALU_SUBN: begin
                            res = vy - vx;
                            wf = 1'b1;
                            flag = (vy > vx) ? 8'd0 : 8'd1;
                        end
                    endcase
                end else if (n != ALU_SHL_NOP) begin
                    st = STAT_ILLEGAL;
                    new_pc = cpu_pc;
                end
            end
            OP_LDIDX: begin
                cpu_index = {4'd0, nnn};
                new_pc = pc_next;
            end
            OP_JPV0: new_pc = nnn + {4'd0, vreg[0]};
            OP_RND, OP_DRW: new_pc = pc_next;
            OP_KEY: begin
                if (nn == KEY_SKP || nn == KEY_SKNP) new_pc = pc_next;
                else st = STAT_ILLEGAL;
            end
            default: begin
                case (nn)
                    FX_ADD_I: begin
                        cpu_index = cpu_index + {8'd0, vx};
                        new_pc = pc_next;
                    end
                    FX_LD_DT, FX_LD_K, FX_SET_DT, FX_SET_ST,
                    FX_FONT, FX_BCD, FX_STORE, FX_LOAD: new_pc = pc_next;
                    default: st = STAT_ILLEGAL;
                endcase
            end
        endcase
        // vf first, so vx wins when x is f
        if (wf) vreg[15] = flag;
        if (wr) vreg[x] = res;
        cpu_pc = new_pc;
        r.next_pc = cpu_pc;
        r.index_value = cpu_index;
        r.reg_write_valid = wr;
        r.reg_write_index = wr ? x : 4'd0;
        r.reg_write_value = wr ? res : 8'd0;
        r.flag_value = vreg[15];
        r.clear_screen = clr;
        r.status = st;
        predicted_outcomes.push_back(r);
    endtask

    // mostly well-formed words, with skips often taken and a slice of raw noise
    function automatic logic [15:0] random_instruction();
        logic [3:0] op, x, y, n;
        logic [7:0] nn;
        int pick;
        x = 4'($urandom_range(0, 15));
        y = 4'($urandom_range(0, 15));
        nn = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 8) return 16'($urandom_range(0, 65535));
        if (pick < 8 + call_weight) return {OP_CALL, 12'($urandom)};
        if (pick < 8 + call_weight + ret_weight) return W_RET;
        op = 4'($urandom_range(0, 15));
        case (op)
            OP_SYS: return $urandom_range(0, 1) ? W_CLS : {OP_SYS, 12'($urandom)};
            OP_SEI, OP_SNEI: begin
                if ($urandom_range(0, 1)) nn = vreg[x];
                return {op, x, nn};
            end
            OP_SER, OP_SNER: begin
                if ($urandom_range(0, 2) == 0) y = x;
                return {op, x, y, 4'($urandom)};
            end
            OP_ALU: begin
                n = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(8, 15))
                                                : 4'($urandom_range(0, 7));
                return {op, x, y, n};
            end
            OP_KEY: begin
                if ($urandom_range(0, 3) != 0) nn = $urandom_range(0, 1) ? KEY_SKP : KEY_SKNP;
                return {op, x, nn};
            end
            OP_MISC: begin
                case ($urandom_range(0, 10))
                    0: nn = FX_LD_DT;
                    1: nn = FX_LD_K;
                    2: nn = FX_SET_DT;
                    3: nn = FX_SET_ST;
                    4, 5: nn = FX_ADD_I;
                    6: nn = FX_FONT;
                    7: nn = FX_BCD;
                    8: nn = FX_STORE;
                    9: nn = FX_LOAD;
                    default: ;
                endcase
                return {op, x, nn};
            end
            default: return {op, x, nn};
        endcase
    endfunction

    // called at a falling edge, returns at the falling edge after the beat is taken
    task automatic send_instruction(input logic [15:0] w);
        int gap;
        if (burst_left == 0) begin
            gap = gaps_on ? $urandom_range(0, 6) : 0;
            burst_left = $urandom_range(1, 24);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1'b1;
        s_instruction <= w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        execute_word(w);
        @(negedge aclk);
    endtask

    task automatic pause_until_drained();
        s_valid <= 1'b0;
        burst_left = 0;
        while (predicted_outcomes.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_program_start(input logic [11:0] start);
        pause_until_drained();
        cfg_valid <= 1'b1;
        cfg_program_start <= start;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cpu_pc = start;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // runs from the reset pc, so the first beat also checks it
    task automatic test_flow_control();
        send_instruction(W_CLS);
        send_instruction({OP_SYS, 12'hFFF});
        send_instruction({OP_JP, 12'hFFE});
        send_instruction({OP_SEI, 4'h0, 8'h00});
        send_instruction({OP_SNER, 4'hF, 4'h0, 4'hF});
        send_instruction({OP_SER, 4'h0, 4'h1, 4'hF});
        send_instruction({OP_LDIDX, 12'hFFF});
        send_instruction({OP_MISC, 4'h0, FX_ADD_I});
        send_instruction({OP_JPV0, 12'hFFF});
        send_instruction({OP_CALL, 12'h000});
        send_instruction(W_RET);
        send_instruction(W_RET);
    endtask

    task automatic test_alu_flags();
        send_instruction({OP_LDI, 4'h0, 8'hFF});
        send_instruction({OP_LDI, 4'h1, 8'h01});
        send_instruction({OP_ALU, 4'h0, 4'h1, 1'b0, ALU_ADD});
        send_instruction({OP_ALU, 4'h0, 4'h1, 1'b0, ALU_SUB});
        send_instruction({OP_ALU, 4'h1, 4'h0, 1'b0, ALU_SUBN});
        send_instruction({OP_ALU, 4'hF, 4'h0, 1'b0, ALU_SHR});
        send_instruction({OP_ALU, 4'h2, 4'h1, 1'b0, ALU_OR});
        send_instruction({OP_ALU, 4'h2, 4'h0, 1'b0, ALU_AND});
        send_instruction({OP_ALU, 4'h2, 4'h1, 1'b0, ALU_XOR});
        send_instruction({OP_ALU, 4'h3, 4'h0, 1'b0, ALU_MOV});
        send_instruction({OP_ADDI, 4'h3, 8'hFF});
        send_instruction({OP_ALU, 4'h0, 4'h0, ALU_SHL_NOP});
    endtask

    task automatic test_illegal_words();
        send_instruction({OP_ALU, 4'h0, 4'h1, ALU_RSVD_LO});
        send_instruction({OP_ALU, 4'hF, 4'hF, ALU_RSVD_HI});
        send_instruction({OP_KEY, 4'h0, 8'h00});
        send_instruction({OP_MISC, 4'hF, 8'hFF});
    endtask

    // program start at both ends of the address space, with pc wrap past the top
    task automatic test_program_start();
        write_program_start(12'hFFF);
        send_instruction({OP_SER, 4'h3, 4'h3, 4'h0});
        write_program_start(12'h000);
        send_instruction({OP_SYS, 12'h123});
        write_program_start(12'hFFE);
        send_instruction({OP_RND, 12'hFFF});
        send_instruction({OP_DRW, 12'hFFF});
    endtask

    task automatic test_index_wrap();
        send_instruction({OP_LDIDX, 12'hFFF});
        send_instruction({OP_LDI, 4'h7, 8'hFF});
        repeat (245) send_instruction({OP_MISC, 4'h7, FX_ADD_I});
    endtask

    task automatic test_stack_limits();
        for (int round = 0; round < 2; round++) begin
            write_program_start(12'($urandom));
            gaps_on = (round == 0);
            // one push past the top
            repeat (STACK_DEPTH + 1) send_instruction({OP_CALL, 12'($urandom)});
            // one pop past the bottom
            repeat (STACK_DEPTH + 1) send_instruction(W_RET);
        end
        gaps_on = 1'b1;
    endtask

    // receiver holds off while the sender keeps offering, so the input stalls
    task automatic test_backpressure();
        hold_request = 1'b1;
        gaps_on = 1'b0;
        repeat (40) send_instruction(random_instruction());
        pause_until_drained();
        gaps_on = 1'b1;
    endtask

    task automatic test_random_programs();
        logic [11:0] starts [6];
        starts[0] = 12'h000;
        starts[1] = 12'hFFF;
        starts[2] = 12'($urandom);
        starts[3] = 12'hFFE;
        starts[4] = PC_RESET;
        starts[5] = 12'($urandom);
        for (int p = 0; p < 6; p++) begin
            write_program_start(starts[p]);
            gaps_on = (p != 2);
            // alternate call-heavy and return-heavy phases to walk the stack end to end
            call_weight = (p % 2 == 0) ? 9 : 4;
            ret_weight = (p % 2 == 0) ? 4 : 9;
            repeat (260) send_instruction(random_instruction());
        end
        gaps_on = 1'b1;
    endtask

    task automatic compare_field(input string what, input logic [15:0] want,
                                 input logic [15:0] got);
        if (got !== want) begin
            errors++;
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
        end
    endtask

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (predicted_outcomes.size() == 0) begin
                errors++;
                $display("%0t: result beat with none expected, got pc %0h", $time, m_next_pc);
            end else begin
                head = predicted_outcomes.pop_front();
                compare_field("next_pc", head.next_pc, m_next_pc);
                compare_field("index_value", head.index_value, m_index_value);
                compare_field("reg_write_valid", head.reg_write_valid, m_reg_write_valid);
                compare_field("reg_write_index", head.reg_write_index, m_reg_write_index);
                compare_field("reg_write_value", head.reg_write_value, m_reg_write_value);
                compare_field("flag_value", head.flag_value, m_flag_value);
                compare_field("clear_screen", head.clear_screen, m_clear_screen);
                compare_field("status", head.status, m_status);
            end
        end
    end

    // receiver: changing stall patterns plus a long hold-off on request
    initial begin : receiver
        rx_mode_t mode;
        int mode_left;
        int beat_phase;
        m_ready = 1'b0;
        mode = RX_OPEN;
        mode_left = 0;
        beat_phase = 0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge aclk);
                hold_request = 1'b0;
            end
            if (mode_left == 0) begin
                mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(16, 160);
            end
            mode_left--;
            beat_phase++;
            case (mode)
                RX_OPEN:   m_ready <= 1'b1;
                RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
                RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
                default:   m_ready <= (beat_phase % 4 != 3);
            endcase
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready))
        begin
            stall_count <= 0;
        end else if (stall_count >= STALL_LIMIT) begin
            $display("%0t: no beat moved for %0d cycles", $time, stall_count);
            $display("FAIL chip8_instruction_execute");
            $finish;
        end else begin
            stall_count <= stall_count + 1;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_instruction = '0;
        cfg_valid = 1'b0;
        cfg_program_start = '0;
        for (int i = 0; i < 16; i++) vreg[i] = '0;
        for (int i = 0; i < STACK_DEPTH; i++) ret_stack[i] = '0;
        cpu_pc = PC_RESET;
        cpu_index = '0;
        stack_level = 0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        test_flow_control();
        test_alu_flags();
        test_illegal_words();
        test_program_start();
        test_index_wrap();
        test_stack_limits();
        test_backpressure();
        test_random_programs();
        pause_until_drained();
        if (errors == 0) begin
            $display("PASS chip8_instruction_execute");
        end else begin
            $display("FAIL chip8_instruction_execute");
        end
        $finish;
    end

endmodule

FILE: files.f
rtl/c8x_pkg.sv
rtl/c8x_decode.sv
rtl/c8x_queue.sv
rtl/c8x_exec.sv
rtl/chip8_instruction_execute.sv
rtl/c8x_checker.sv
verif/tb.sv
